FILE: design/tabular_q_learning_update_defines.svh
// shared assertion macros for the q-learning update block
`ifndef TABULAR_Q_LEARNING_UPDATE_DEFINES_SVH
`define TABULAR_Q_LEARNING_UPDATE_DEFINES_SVH

// same-cycle implication, checked out of reset
`define TQLU_ASSERT_IMP(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, checked out of reset
`define TQLU_ASSERT_NXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: design/tqlu_pkg.sv
package tqlu_pkg;

    localparam int STATE_W    = 4;
    localparam int ACT_W      = 2;
    localparam int MODE_W     = 2;
    localparam int REWARD_W   = 8;
    localparam int DRAW_W     = 7;
    localparam int RATE_W     = 17;
    localparam int Q_W        = 32;
    localparam int CFG_IDX_W  = 2;
    localparam int IN_DATA_W  = 32;
    localparam int OUT_DATA_W = 72;
    localparam int N_ACT      = 4;

    localparam logic [MODE_W-1:0] MODE_EXPLORE = 2'd0;
    localparam logic [MODE_W-1:0] MODE_GREEDY  = 2'd1;
    localparam logic [MODE_W-1:0] MODE_UPDATE  = 2'd2;

    localparam logic [CFG_IDX_W-1:0] CFG_LEARNING_RATE = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_DISCOUNT      = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_EXPLORE_RATE  = 2'd2;

    localparam logic [RATE_W-1:0] LEARNING_RATE_RST = 17'd6554;
    localparam logic [RATE_W-1:0] DISCOUNT_RST      = 17'd58982;
    localparam logic [RATE_W-1:0] EXPLORE_RATE_RST  = 17'd65536;

    typedef struct packed {
        logic [RATE_W-1:0] learning_rate;
        logic [RATE_W-1:0] discount;
        logic [RATE_W-1:0] explore_rate;
    } t_cfg;

    typedef struct packed {
        logic load_item;
        logic find_max;
        logic mul_en;
        logic mul_lr;
        logic sum_en;
        logic finish;
        logic clear_en;
    } t_cmd;

    typedef struct packed {
        logic is_update;
        logic clear_last;
        logic out_busy;
    } t_stat;

endpackage

FILE: design/tqlu_cfg.sv
module tqlu_cfg
    import tqlu_pkg::*;
(
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_cfg_valid,
    output logic                 o_cfg_ready,
    input  logic [CFG_IDX_W-1:0] i_cfg_index,
    input  logic [RATE_W-1:0]    i_cfg_data,
    output t_cfg                 o_cfg
);

    t_cfg r_cfg;
    t_cfg n_cfg;

    always_comb begin
        n_cfg = r_cfg;
        if (i_cfg_valid) begin
            unique case (i_cfg_index)
                CFG_LEARNING_RATE: n_cfg.learning_rate = i_cfg_data;
                CFG_DISCOUNT:      n_cfg.discount      = i_cfg_data;
                CFG_EXPLORE_RATE:  n_cfg.explore_rate  = i_cfg_data;
                default:           n_cfg               = r_cfg;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.learning_rate <= LEARNING_RATE_RST;
            r_cfg.discount      <= DISCOUNT_RST;
            r_cfg.explore_rate  <= EXPLORE_RATE_RST;
        end else begin
            r_cfg <= n_cfg;
        end
    end

    assign o_cfg_ready = 1'b1;
    assign o_cfg       = r_cfg;

endmodule

FILE: design/tqlu_dp.sv
`include "tabular_q_learning_update_defines.svh"

module tqlu_dp
    import tqlu_pkg::*;
#(
    parameter int NUM_STATES = 16
)
(
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  t_cmd                       i_cmd,
    output t_stat                      o_stat,
    input  t_cfg                       i_cfg,
    input  logic [MODE_W-1:0]          i_mode,
    input  logic [STATE_W-1:0]         i_current_state,
    input  logic [ACT_W-1:0]           i_taken_action,
    input  logic [STATE_W-1:0]         i_next_state,
    input  logic signed [REWARD_W-1:0] i_reward,
    input  logic [DRAW_W-1:0]          i_rand_gate,
    input  logic [DRAW_W-1:0]          i_rand_pick,
    output logic                       o_out_valid,
    input  logic                       i_out_ready,
    output logic [ACT_W-1:0]           o_chosen_action,
    output logic signed [Q_W-1:0]      o_written_value,
    output logic signed [Q_W-1:0]      o_reward_sum
);

    localparam int AW = $clog2(NUM_STATES);

    function automatic logic signed [Q_W-1:0] sat32(input logic signed [35:0] v);
        logic signed [Q_W-1:0] res;
        if (v > 36'sd2147483647) begin
            res = 32'sh7FFFFFFF;
        end else if (v < -36'sd2147483648) begin
            res = 32'sh80000000;
        end else begin
            res = v[Q_W-1:0];
        end
        return res;
    endfunction

    // one column memory per action, all read at the same row
    logic signed [Q_W-1:0] r_qmem_0 [NUM_STATES];
    logic signed [Q_W-1:0] r_qmem_1 [NUM_STATES];
    logic signed [Q_W-1:0] r_qmem_2 [NUM_STATES];
    logic signed [Q_W-1:0] r_qmem_3 [NUM_STATES];
    logic signed [Q_W-1:0] r_rd [N_ACT];

    logic [AW-1:0]                r_clr_addr;
    logic                         r_is_update;
    logic                         r_cs_ok;
    logic                         r_row_ok;
    logic [AW-1:0]                r_wr_addr;
    logic [ACT_W-1:0]             r_ta;
    logic signed [REWARD_W-1:0]   r_reward;
    logic                         r_explore;
    logic [ACT_W-1:0]             r_pick;
    logic signed [Q_W-1:0]        r_max;
    logic [ACT_W-1:0]             r_act;
    logic signed [49:0]           r_prod;
    logic signed [Q_W-1:0]        r_inner;
    logic signed [Q_W-1:0]        r_total;
    logic                         r_out_valid;
    logic [ACT_W-1:0]             r_out_action;
    logic signed [Q_W-1:0]        r_out_written;
    logic signed [Q_W-1:0]        r_out_sum;

    logic [STATE_W-1:0]           w_rd_state;
    logic                         w_rd_ok;
    logic                         w_cs_ok;
    logic [AW-1:0]                w_rd_addr;
    logic [23:0]                  w_gate_prod;
    logic signed [Q_W-1:0]        w_q [N_ACT];
    logic [ACT_W-1:0]             w_best01;
    logic [ACT_W-1:0]             w_best23;
    logic signed [Q_W-1:0]        w_val01;
    logic signed [Q_W-1:0]        w_val23;
    logic [RATE_W-1:0]            w_mul_a;
    logic signed [Q_W-1:0]        w_mul_b;
    logic signed [49:0]           w_prod;
    logic signed [49:0]           w_prod_rnd;
    logic signed [33:0]           w_round;
    logic signed [35:0]           w_inner_wide;
    logic signed [Q_W-1:0]        w_written;
    logic signed [35:0]           w_total_wide;
    logic signed [Q_W-1:0]        w_total_new;
    logic [N_ACT-1:0]             w_we;
    logic [AW-1:0]                w_waddr;
    logic signed [Q_W-1:0]        w_wdata;

    // row fetch address at item load
    assign w_rd_state  = (i_mode == MODE_UPDATE) ? i_next_state : i_current_state;
    assign w_rd_ok     = 32'(w_rd_state) < 32'(NUM_STATES);
    assign w_cs_ok     = 32'(i_current_state) < 32'(NUM_STATES);
    assign w_rd_addr   = AW'(w_rd_state);
    assign w_gate_prod = 24'(i_rand_gate) * 24'(i_cfg.explore_rate);

    // memory write port: clearing pass or the update store
    assign w_waddr = i_cmd.clear_en ? r_clr_addr : r_wr_addr;
    assign w_wdata = i_cmd.clear_en ? '0 : w_written;

    always_comb begin
        for (int k = 0; k < N_ACT; k++) begin
            w_we[k] = i_cmd.clear_en ||
                      (i_cmd.finish && r_is_update && r_cs_ok && (r_ta == ACT_W'(k)));
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_we[0]) r_qmem_0[w_waddr] <= w_wdata;
        if (i_cmd.load_item) r_rd[0] <= r_qmem_0[w_rd_addr];
    end

    always_ff @(posedge i_clk) begin
        if (w_we[1]) r_qmem_1[w_waddr] <= w_wdata;
        if (i_cmd.load_item) r_rd[1] <= r_qmem_1[w_rd_addr];
    end

    always_ff @(posedge i_clk) begin
        if (w_we[2]) r_qmem_2[w_waddr] <= w_wdata;
        if (i_cmd.load_item) r_rd[2] <= r_qmem_2[w_rd_addr];
    end

    always_ff @(posedge i_clk) begin
        if (w_we[3]) r_qmem_3[w_waddr] <= w_wdata;
        if (i_cmd.load_item) r_rd[3] <= r_qmem_3[w_rd_addr];
    end

    // rows beyond the table read as zero
    always_comb begin
        for (int k = 0; k < N_ACT; k++) begin
            w_q[k] = r_row_ok ? r_rd[k] : '0;
        end
    end

    // first maximum: ties keep the lower column
    assign w_best01 = (w_q[1] > w_q[0]) ? 2'd1 : 2'd0;
    assign w_val01  = (w_q[1] > w_q[0]) ? w_q[1] : w_q[0];
    assign w_best23 = (w_q[3] > w_q[2]) ? 2'd3 : 2'd2;
    assign w_val23  = (w_q[3] > w_q[2]) ? w_q[3] : w_q[2];

    // shared multiplier: discount times row max, then learning rate times inner sum
    assign w_mul_a    = i_cmd.mul_lr ? i_cfg.learning_rate : i_cfg.discount;
    assign w_mul_b    = i_cmd.mul_lr ? r_inner : r_max;
    assign w_prod     = 50'($signed({1'b0, w_mul_a})) * 50'(w_mul_b);
    assign w_prod_rnd = r_prod + 50'sd32768;
    assign w_round    = w_prod_rnd[49:16];

    assign w_inner_wide = {{12{r_reward[REWARD_W-1]}}, r_reward, 16'b0}
                        + {{2{w_round[33]}}, w_round};
    assign w_written    = sat32({{2{w_round[33]}}, w_round});
    assign w_total_wide = {{4{r_total[Q_W-1]}}, r_total}
                        + {{28{r_reward[REWARD_W-1]}}, r_reward};
    assign w_total_new  = sat32(w_total_wide);

    always_ff @(posedge i_clk) begin
        if (i_cmd.load_item) begin
            r_is_update <= (i_mode == MODE_UPDATE);
            r_cs_ok     <= w_cs_ok;
            r_row_ok    <= w_rd_ok;
            r_wr_addr   <= AW'(i_current_state);
            r_ta        <= i_taken_action;
            r_reward    <= i_reward;
            r_explore   <= (i_mode == MODE_EXPLORE) && (w_gate_prod[23:16] != 8'd0);
            r_pick      <= i_rand_pick[ACT_W-1:0];
        end
        if (i_cmd.find_max) begin
            r_act <= (w_val23 > w_val01) ? w_best23 : w_best01;
            r_max <= (w_val23 > w_val01) ? w_val23 : w_val01;
        end
        if (i_cmd.mul_en) begin
            r_prod <= w_prod;
        end
        if (i_cmd.sum_en) begin
            r_inner <= sat32(w_inner_wide);
        end
        if (i_cmd.finish) begin
            r_out_action  <= r_is_update ? '0 : (r_explore ? r_pick : r_act);
            r_out_written <= r_is_update ? w_written : '0;
            r_out_sum     <= r_is_update ? w_total_new : r_total;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clr_addr  <= '0;
            r_total     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cmd.clear_en) begin
                r_clr_addr <= r_clr_addr + 1'b1;
            end
            if (i_cmd.finish && r_is_update) begin
                r_total <= w_total_new;
            end
            if (i_cmd.finish) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    assign o_stat.is_update  = r_is_update;
    assign o_stat.clear_last = (r_clr_addr == AW'(NUM_STATES - 1));
    assign o_stat.out_busy   = r_out_valid && !i_out_ready;

    assign o_out_valid     = r_out_valid;
    assign o_chosen_action = r_out_action;
    assign o_written_value = r_out_written;
    assign o_reward_sum    = r_out_sum;

    `TQLU_ASSERT_NXT(a_finish_shows, i_cmd.finish, r_out_valid, "result not presented")
    `TQLU_ASSERT_IMP(a_lr_on_update, i_cmd.mul_en && i_cmd.mul_lr, r_is_update, "lr multiply on select")
    `TQLU_ASSERT_IMP(a_clear_alone, i_cmd.clear_en, !i_cmd.load_item && !i_cmd.finish, "item during clear")

endmodule

FILE: design/tqlu_ctrl.sv
`include "tabular_q_learning_update_defines.svh"

module tqlu_ctrl
    import tqlu_pkg::*;
(
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  i_s_valid,
    output logic  o_s_ready,
    input  t_stat i_stat,
    output t_cmd  o_cmd
);

    localparam logic [2:0] S_CLEAR = 3'd0;
    localparam logic [2:0] S_IDLE  = 3'd1;
    localparam logic [2:0] S_MAX   = 3'd2;
    localparam logic [2:0] S_MUL1  = 3'd3;
    localparam logic [2:0] S_SUM   = 3'd4;
    localparam logic [2:0] S_MUL2  = 3'd5;
    localparam logic [2:0] S_FIN   = 3'd6;

    logic [2:0] r_state;
    logic [2:0] n_state;

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        unique case (r_state)
            S_CLEAR: begin
                o_cmd.clear_en = 1'b1;
                if (i_stat.clear_last) n_state = S_IDLE;
            end
            S_IDLE: begin
                if (i_s_valid) begin
                    o_cmd.load_item = 1'b1;
                    n_state         = S_MAX;
                end
            end
            S_MAX: begin
                o_cmd.find_max = 1'b1;
                n_state        = i_stat.is_update ? S_MUL1 : S_FIN;
            end
            S_MUL1: begin
                o_cmd.mul_en = 1'b1;
                n_state      = S_SUM;
            end
            S_SUM: begin
                o_cmd.sum_en = 1'b1;
                n_state      = S_MUL2;
            end
            S_MUL2: begin
                o_cmd.mul_en = 1'b1;
                o_cmd.mul_lr = 1'b1;
                n_state      = S_FIN;
            end
            S_FIN: begin
                // hold until the output register is free
                if (!i_stat.out_busy) begin
                    o_cmd.finish = 1'b1;
                    n_state      = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_CLEAR;
        end else begin
            r_state <= n_state;
        end
    end

    assign o_s_ready = (r_state == S_IDLE);

    `TQLU_ASSERT_IMP(a_no_overwrite, o_cmd.finish, !i_stat.out_busy, "result overwritten")
    `TQLU_ASSERT_NXT(a_load_to_max, o_cmd.load_item, r_state == S_MAX, "load not followed by max")
    `TQLU_ASSERT_IMP(a_busy_in_clear, r_state == S_CLEAR, !o_s_ready, "ready during clear")

endmodule

FILE: design/tabular_q_learning_update.sv
// Tabular Q-learning agent core: a Q table of NUM_STATES rows by 4 actions (Q16.16)
// and a saturating reward total. Items enter on the s_axis channel (tuser = mode),
// results leave on m_axis, one result per item. Rates are written on the cfg channel
// (index 0 learning rate, 1 discount, 2 explore rate, Q1.16); write only while idle.
// Select items (mode 0 explore, 1 or 3 greedy) pass through row read at the accepting
// edge, row maximum and output load. Update items (mode 2) pass through row read at
// accept, row maximum, discount multiply, inner sum, learning-rate multiply, then
// store and output load on the same edge.
// One item is in flight at a time; the next item is taken on the cycle after the
// result is loaded, so no new item is taken before the last one is done.
// The two multiplies share one 18x32 multiplier and set the update length.
// After reset the table is cleared one row a cycle, all NUM_STATES rows, with
// s_axis_tready low; config writes are taken at any time.
// When m_axis_tready is low the finished result holds in the output register and
// the block waits to load the next result until it is taken.
module tabular_q_learning_update
    import tqlu_pkg::*;
#(
    parameter int NUM_STATES = 16
)
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  s_axis_tvalid,
    output logic                  s_axis_tready,
    // current_state[3:0], taken_action[5:4], next_state[9:6], reward[17:10],
    // rand_gate[24:18], rand_pick[31:25]
    input  logic [IN_DATA_W-1:0]  s_axis_tdata,
    // mode[1:0]
    input  logic [MODE_W-1:0]     s_axis_tuser,
    output logic                  m_axis_tvalid,
    input  logic                  m_axis_tready,
    // chosen_action[1:0], written_value[33:2], reward_sum[65:34], zero[71:66]
    output logic [OUT_DATA_W-1:0] m_axis_tdata,
    input  logic                  i_cfg_valid,
    output logic                  o_cfg_ready,
    input  logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [RATE_W-1:0]     i_cfg_data
);

    t_cfg                  w_cfg;
    t_cmd                  w_cmd;
    t_stat                 w_stat;
    logic [ACT_W-1:0]      w_chosen_action;
    logic signed [Q_W-1:0] w_written_value;
    logic signed [Q_W-1:0] w_reward_sum;

    tqlu_cfg u_cfg (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .o_cfg       (w_cfg)
    );

    tqlu_ctrl u_ctrl (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_s_valid (s_axis_tvalid),
        .o_s_ready (s_axis_tready),
        .i_stat    (w_stat),
        .o_cmd     (w_cmd)
    );

    tqlu_dp #(
        .NUM_STATES (NUM_STATES)
    ) u_dp (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cmd           (w_cmd),
        .o_stat          (w_stat),
        .i_cfg           (w_cfg),
        .i_mode          (s_axis_tuser),
        .i_current_state (s_axis_tdata[3:0]),
        .i_taken_action  (s_axis_tdata[5:4]),
        .i_next_state    (s_axis_tdata[9:6]),
        .i_reward        ($signed(s_axis_tdata[17:10])),
        .i_rand_gate     (s_axis_tdata[24:18]),
        .i_rand_pick     (s_axis_tdata[31:25]),
        .o_out_valid     (m_axis_tvalid),
        .i_out_ready     (m_axis_tready),
        .o_chosen_action (w_chosen_action),
        .o_written_value (w_written_value),
        .o_reward_sum    (w_reward_sum)
    );

    assign m_axis_tdata = {6'b0, w_reward_sum, w_written_value, w_chosen_action};

endmodule

FILE: bench/tqlu_tb_pkg.sv
`timescale 1ns / 1ps
package tqlu_tb_pkg;
    import tqlu_pkg::*;

    localparam int TB_NUM_STATES = 16;
    localparam int MAX_REPORTS   = 40;

    // mode 3 has no function of its own and selects greedily
    localparam logic [MODE_W-1:0]    MODE_SPARE = 2'd3;
    // index 3 maps to no register
    localparam logic [CFG_IDX_W-1:0] CFG_SPARE  = 2'd3;

    // result layout on m_axis_tdata
    localparam int ACT_LSB = 0;
    localparam int VAL_LSB = ACT_W;
    localparam int SUM_LSB = ACT_W + Q_W;
    localparam int PAD_LSB = ACT_W + 2 * Q_W;
    localparam int PAD_W   = OUT_DATA_W - PAD_LSB;

    localparam longint ONE_Q16 = 64'sd65536;
    localparam longint Q_MAX   = 64'sh7fff_ffff;
    localparam longint Q_MIN   = -64'sh8000_0000;

    typedef struct {
        logic [MODE_W-1:0]          mode;
        logic [STATE_W-1:0]         cur;
        logic [ACT_W-1:0]           act;
        logic [STATE_W-1:0]         nxt;
        logic signed [REWARD_W-1:0] reward;
        logic [DRAW_W-1:0]          gate;
        logic [DRAW_W-1:0]          pick;
    } t_q_item;

    typedef struct {
        int               seq;
        logic [ACT_W-1:0] action;
        logic [Q_W-1:0]   value;
        logic [Q_W-1:0]   total;
    } t_q_result;

    class t_q_scoreboard;
        int                q_cells[TB_NUM_STATES * N_ACT];
        int                reward_acc;
        logic [RATE_W-1:0] lr;
        logic [RATE_W-1:0] disc;
        logic [RATE_W-1:0] expl;
        t_q_result         pending[$];
        int                errors;
        int                n_items;
        int                n_checked;
        int                n_updates;
        int                n_explored;
        int                n_greedy;
        int                n_saturated;
        int                n_reg_writes;

        function new();
            lr   = LEARNING_RATE_RST;
            disc = DISCOUNT_RST;
            expl = EXPLORE_RATE_RST;
        endfunction

        function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [RATE_W-1:0] val);
            n_reg_writes++;
            case (idx)
                CFG_LEARNING_RATE: lr   = val;
                CFG_DISCOUNT:      disc = val;
                CFG_EXPLORE_RATE:  expl = val;
                default: ;
            endcase
        endfunction

        // rows past the table read as zero
        function int q_at(int row, int col);
            if (row >= TB_NUM_STATES) return 0;
            return q_cells[row * N_ACT + col];
        endfunction

        // first column holding the row maximum
        function int greedy_col(int row);
            int best;
            best = 0;
            for (int c = 1; c < N_ACT; c++)
                if (q_at(row, c) > q_at(row, best)) best = c;
            return best;
        endfunction

        function longint sat32(longint v);
            if (v > Q_MAX) return Q_MAX;
            if (v < Q_MIN) return Q_MIN;
            return v;
        endfunction

        // q1.16 rate times q16.16 value, round half up
        function longint round_mul(logic [RATE_W-1:0] rate, longint q);
            return (longint'(rate) * q + 64'sd32768) >>> 16;
        endfunction

        function void note_item(t_q_item it);
            t_q_result want;
            longint    inner;
            longint    raw;
            int        row_peak;
            want.seq    = n_items;
            want.action = '0;
            want.value  = '0;
            n_items++;
            if (it.mode == MODE_UPDATE) begin
                row_peak = q_at(it.nxt, greedy_col(it.nxt));
                inner = longint'(it.reward) * ONE_Q16 + round_mul(disc, row_peak);
                raw = round_mul(lr, sat32(inner));
                if (raw != sat32(raw)) n_saturated++;
                if (it.cur < TB_NUM_STATES) q_cells[it.cur * N_ACT + it.act] = int'(sat32(raw));
                want.value = Q_W'(sat32(raw));
                reward_acc = int'(sat32(longint'(reward_acc) + longint'(it.reward)));
                n_updates++;
            end else if (it.mode == MODE_EXPLORE && longint'(it.gate) * longint'(expl) >= ONE_Q16)
            begin
                want.action = it.pick[ACT_W-1:0];
                n_explored++;
            end else begin
                want.action = ACT_W'(greedy_col(it.cur));
                n_greedy++;
            end
            want.total = reward_acc;
            pending.push_back(want);
        endfunction

        task report_mismatch(string msg);
            errors++;
            if (errors <= MAX_REPORTS) $display("[%0t] mismatch: %s", $time, msg);
        endtask

        task check_result(logic [OUT_DATA_W-1:0] d);
            t_q_result want;
            if (pending.size() == 0) begin
                report_mismatch($sformatf("result %h with no item outstanding", d));
                return;
            end
            want = pending.pop_front();
            n_checked++;
            if (d[ACT_LSB +: ACT_W] !== want.action)
                report_mismatch($sformatf("item %0d chosen_action %0d, expected %0d",
                    want.seq, d[ACT_LSB +: ACT_W], want.action));
            if (d[VAL_LSB +: Q_W] !== want.value)
                report_mismatch($sformatf("item %0d written_value %h, expected %h",
                    want.seq, d[VAL_LSB +: Q_W], want.value));
            if (d[SUM_LSB +: Q_W] !== want.total)
                report_mismatch($sformatf("item %0d reward_sum %h, expected %h",
                    want.seq, d[SUM_LSB +: Q_W], want.total));
            if (d[PAD_LSB +: PAD_W] !== '0)
                report_mismatch($sformatf("item %0d padding bits %h not zero",
                    want.seq, d[PAD_LSB +: PAD_W]));
        endtask
    endclass

endpackage

FILE: bench/tabular_q_learning_update_tb.sv
`timescale 1ns / 1ps
module tabular_q_learning_update_tb
    import tqlu_pkg::*;
    import tqlu_tb_pkg::*;
();

    localparam int CLK_HALF      = 6;
    localparam int RST_CYCLES    = 6;
    localparam int CYCLE_LIMIT   = 400000;
    localparam int SEGMENTS      = 6;
    localparam int SEG_ITEMS     = 258;
    localparam int DRAIN_EVERY   = 97;
    localparam int SETTLE_CYCLES = 8;
    localparam int TAIL_CYCLES   = 20;

    logic                  i_clk         = 1'b0;
    logic                  i_rst_n       = 1'b0;
    logic                  s_axis_tvalid = 1'b0;
    logic                  s_axis_tready;
    logic [IN_DATA_W-1:0]  s_axis_tdata  = '0;
    logic [MODE_W-1:0]     s_axis_tuser  = '0;
    logic                  m_axis_tvalid;
    logic                  m_axis_tready = 1'b0;
    logic [OUT_DATA_W-1:0] m_axis_tdata;
    logic                  i_cfg_valid   = 1'b0;
    logic                  o_cfg_ready;
    logic [CFG_IDX_W-1:0]  i_cfg_index   = '0;
    logic [RATE_W-1:0]     i_cfg_data    = '0;

    int tx_idle_pct = 36;
    int rx_idle_pct = 53;
    int cycle_count = 0;

    t_q_scoreboard q_check = new;

    tabular_q_learning_update #(
        .NUM_STATES(TB_NUM_STATES)
    ) u_dut (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .s_axis_tvalid(s_axis_tvalid),
        .s_axis_tready(s_axis_tready),
        .s_axis_tdata (s_axis_tdata),
        .s_axis_tuser (s_axis_tuser),
        .m_axis_tvalid(m_axis_tvalid),
        .m_axis_tready(m_axis_tready),
        .m_axis_tdata (m_axis_tdata),
        .i_cfg_valid  (i_cfg_valid),
        .o_cfg_ready  (o_cfg_ready),
        .i_cfg_index  (i_cfg_index),
        .i_cfg_data   (i_cfg_data)
    );

    initial begin
        forever #CLK_HALF i_clk = ~i_clk;
    end

    always @(negedge i_clk) begin
        m_axis_tready <= ($urandom_range(0, 99) >= rx_idle_pct);
    end

    always @(posedge i_clk) begin
        if (i_rst_n && m_axis_tvalid && m_axis_tready) q_check.check_result(m_axis_tdata);
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("timeout after %0d cycles, %0d results outstanding",
                cycle_count, q_check.pending.size());
            $display("CHECKS FAILED");
            $finish;
        end
    end

    function automatic t_q_item mk(logic [MODE_W-1:0] mode, logic [STATE_W-1:0] cur,
                                   logic [ACT_W-1:0] act, logic [STATE_W-1:0] nxt,
                                   logic signed [REWARD_W-1:0] reward,
                                   logic [DRAW_W-1:0] gate, logic [DRAW_W-1:0] pick);
        t_q_item it;
        it.mode   = mode;
        it.cur    = cur;
        it.act    = act;
        it.nxt    = nxt;
        it.reward = reward;
        it.gate   = gate;
        it.pick   = pick;
        return it;
    endfunction

    function automatic t_q_item random_item();
        t_q_item it;
        int      sel;
        sel = $urandom_range(0, 99);
        if (sel < 45)      it.mode = MODE_UPDATE;
        else if (sel < 70) it.mode = MODE_EXPLORE;
        else if (sel < 90) it.mode = MODE_GREEDY;
        else               it.mode = MODE_SPARE;
        it.cur = STATE_W'($urandom);
        it.act = ACT_W'($urandom);
        it.nxt = STATE_W'($urandom);
        sel = $urandom_range(0, 9);
        if (sel == 0)      it.reward = 8'h80;
        else if (sel == 1) it.reward = 8'h7f;
        else               it.reward = REWARD_W'($urandom);
        // a zero gate always acts greedily; mostly draws in the nominal range
        sel = $urandom_range(0, 9);
        if (sel < 2)       it.gate = '0;
        else if (sel < 8)  it.gate = DRAW_W'($urandom_range(0, 100));
        else               it.gate = DRAW_W'($urandom);
        it.pick = DRAW_W'($urandom);
        return it;
    endfunction

    // leaves tvalid high on return so back-to-back items need no extra edge
    task automatic send_item(input t_q_item it);
        while ($urandom_range(0, 99) < tx_idle_pct) begin
            s_axis_tvalid <= 1'b0;
            @(negedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tuser  <= it.mode;
        s_axis_tdata  <= {it.pick, it.gate, it.reward, it.nxt, it.act, it.cur};
        @(posedge i_clk);
        while (!s_axis_tready) @(posedge i_clk);
        q_check.note_item(it);
        @(negedge i_clk);
    endtask

    task automatic wait_drained();
        s_axis_tvalid <= 1'b0;
        @(negedge i_clk);
        while (q_check.pending.size() != 0) @(negedge i_clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [RATE_W-1:0] val);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= val;
        @(posedge i_clk);
        while (!o_cfg_ready) @(posedge i_clk);
        q_check.write_reg(idx, val);
        @(negedge i_clk);
    endtask

    task automatic configure(input logic [RATE_W-1:0] lr, input logic [RATE_W-1:0] disc,
                             input logic [RATE_W-1:0] expl);
        repeat (SETTLE_CYCLES) @(negedge i_clk);
        write_reg(CFG_LEARNING_RATE, lr);
        write_reg(CFG_DISCOUNT, disc);
        write_reg(CFG_EXPLORE_RATE, expl);
        write_reg(CFG_SPARE, RATE_W'($urandom));
        i_cfg_valid <= 1'b0;
    endtask

    initial begin
        repeat (RST_CYCLES) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // directed items under reset rates
        send_item(mk(MODE_GREEDY,  4'd0,  2'd0, 4'd0,  8'sd0,   7'd0,   7'd0));
        send_item(mk(MODE_EXPLORE, 4'd0,  2'd0, 4'd0,  8'sd0,   7'd0,   7'd127));
        send_item(mk(MODE_EXPLORE, 4'd1,  2'd0, 4'd0,  8'sd0,   7'd1,   7'd127));
        send_item(mk(MODE_EXPLORE, 4'd2,  2'd0, 4'd0,  8'sd0,   7'd100, 7'd2));
        send_item(mk(MODE_EXPLORE, 4'd3,  2'd0, 4'd0,  8'sd0,   7'd127, 7'd1));
        send_item(mk(MODE_SPARE,   4'd15, 2'd0, 4'd0,  8'sd0,   7'd0,   7'd0));
        send_item(mk(MODE_UPDATE,  4'd15, 2'd3, 4'd0,  8'h7f,   7'd0,   7'd0));
        send_item(mk(MODE_UPDATE,  4'd0,  2'd0, 4'd15, 8'h80,   7'd0,   7'd0));
        send_item(mk(MODE_UPDATE,  4'd5,  2'd2, 4'd15, 8'sd1,   7'd0,   7'd0));
        // equal values in two columns: greedy keeps the lower one
        send_item(mk(MODE_UPDATE,  4'd5,  2'd1, 4'd15, 8'sd1,   7'd0,   7'd0));
        send_item(mk(MODE_GREEDY,  4'd5,  2'd0, 4'd0,  8'sd0,   7'd0,   7'd0));
        send_item(mk(MODE_UPDATE,  4'd5,  2'd0, 4'd5,  8'hff,   7'd0,   7'd0));
        send_item(mk(MODE_SPARE,   4'd0,  2'd0, 4'd0,  8'sd0,   7'd0,   7'd0));
        send_item(mk(MODE_UPDATE,  4'd7,  2'd3, 4'd0,  8'sd0,   7'd0,   7'd0));
        send_item(mk(MODE_UPDATE,  4'd15, 2'd3, 4'd15, 8'hff,   7'd127, 7'd127));
        send_item(mk(MODE_EXPLORE, 4'd0,  2'd0, 4'd0,  8'sd0,   7'd0,   7'd0));
        send_item(mk(MODE_UPDATE,  4'd3,  2'd1, 4'd3,  8'hff,   7'd0,   7'd0));
        send_item(mk(MODE_EXPLORE, 4'd15, 2'd0, 4'd0,  8'sd0,   7'd127, 7'd0));
        send_item(mk(MODE_GREEDY,  4'd15, 2'd0, 4'd0,  8'sd0,   7'd0,   7'd0));
        wait_drained();

        for (int seg = 0; seg < SEGMENTS; seg++) begin
            if (seg < 2) begin
                tx_idle_pct = 36;
                rx_idle_pct = 53;
            end else if (seg < 4) begin
                tx_idle_pct = 53;
                rx_idle_pct = 36;
            end else begin
                tx_idle_pct = 0;
                rx_idle_pct = 0;
            end
            case (seg)
                0: configure(17'd65536, 17'd65536, 17'd65536);
                // rates near two drive the table into saturation
                1: configure(17'h1ffff, 17'h1ffff, 17'h1ffff);
                2: configure(17'd0, 17'd0, 17'd0);
                // explore threshold just past a gate of 100
                4: configure(LEARNING_RATE_RST, DISCOUNT_RST, 17'd655);
                default: configure(RATE_W'($urandom), RATE_W'($urandom), RATE_W'($urandom));
            endcase
            for (int k = 0; k < SEG_ITEMS; k++) begin
                send_item(random_item());
                if (k % DRAIN_EVERY == DRAIN_EVERY - 1) wait_drained();
            end
            wait_drained();
        end

        repeat (TAIL_CYCLES) @(negedge i_clk);
        $display("covered %0d items: %0d updates (%0d saturated), %0d explored, %0d greedy",
            q_check.n_items, q_check.n_updates, q_check.n_saturated,
            q_check.n_explored, q_check.n_greedy);
        $display("%0d register writes over %0d rate settings, %0d results checked, %0d mismatches",
            q_check.n_reg_writes, SEGMENTS, q_check.n_checked, q_check.errors);
        if (q_check.errors == 0 && q_check.pending.size() == 0) begin
            $display("ALL CHECKS PASSED");
        end else begin
            $display("CHECKS FAILED");
        end
        $finish;
    end

endmodule
